FILE: rtl/des_pkg.sv
package des_pkg;

  localparam int unsigned Rounds = 16;
  localparam int unsigned BlockW = 64;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned SubkW  = 48;
  localparam int unsigned HalfW  = 28;

  typedef logic [SubkW-1:0] subkey_t;

  // 1-based tables, entry 1 is the MSB of the source word
  localparam byte unsigned TblIp [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam byte unsigned TblFp [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam byte unsigned TblE [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam byte unsigned TblP [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

  localparam byte unsigned TblPc1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

  localparam byte unsigned TblPc2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  localparam byte unsigned TblShift [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam byte unsigned TblS [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TblIp[i])];
    return r;
  endfunction

  function automatic logic [63:0] fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TblFp[i])];
    return r;
  endfunction

  function automatic logic [55:0] pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(TblPc1[i])];
    return r;
  endfunction

  function automatic subkey_t pc2(input logic [55:0] v);
    subkey_t r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(TblPc2[i])];
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] rh, input subkey_t k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = rh[32-int'(TblE[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      six = x[(7-i)*6 +: 6];
      s[(7-i)*4 +: 4] = TblS[i][{six[5], six[0], six[4:1]}][3:0];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TblP[i])];
    return p;
  endfunction

endpackage

FILE: rtl/des_block_cipher.sv
// done_o rises after the edge that takes a start beat, once the block has passed the
// input register, 16 round stages and the output register.
// Throughput: one block per cycle; busy is low except while subkeys are derived.
// Subkeys are derived one round per cycle after reset and after every key write,
// with busy high while they are derived. Reset loads key 0. The receiver cannot stall:
// each result is shown for one cycle with done_o high.
module des_block_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        op_i,
  input  logic [63:0] block_in_i,
  input  logic        key_we_i,
  input  logic [63:0] cipher_key_i,
  output logic        done_o,
  output logic [63:0] block_out_o
);

  localparam int unsigned R = des_pkg::Rounds;

  // key schedule: one rotation step a cycle
  des_pkg::subkey_t    subk_q [R];
  logic [27:0]         c_q, d_q, c_d, d_d;
  logic [4:0]          kcnt_q;
  logic                kbusy_q;
  logic [3:0]          kidx;
  logic [55:0]         key_cd;

  assign kidx   = kcnt_q[3:0];
  assign key_cd = des_pkg::pc1(cipher_key_i);

  always_comb begin
    if (des_pkg::TblShift[kidx] == 8'd1) begin
      c_d = {c_q[26:0], c_q[27]};
      d_d = {d_q[26:0], d_q[27]};
    end else begin
      c_d = {c_q[25:0], c_q[27:26]};
      d_d = {d_q[25:0], d_q[27:26]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q     <= '0;
      d_q     <= '0;
      kcnt_q  <= '0;
      kbusy_q <= 1'b1;
    end else if (key_we_i) begin
      c_q     <= key_cd[55:28];
      d_q     <= key_cd[27:0];
      kcnt_q  <= '0;
      kbusy_q <= 1'b1;
    end else if (kbusy_q) begin
      c_q    <= c_d;
      d_q    <= d_d;
      kcnt_q <= kcnt_q + 5'd1;
      if (kcnt_q == 5'(R - 1)) kbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (kbusy_q && !key_we_i) subk_q[kidx] <= des_pkg::pc2({c_d, d_d});
  end

  assign busy_o = kbusy_q;

  // input stage
  logic        in_vld_q, in_op_q;
  logic [63:0] in_lr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !kbusy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in_lr_q <= des_pkg::ip(block_in_i);
    in_op_q <= op_i;
  end

  logic        vld [R+1];
  logic        opc [R+1];
  logic [63:0] lr  [R+1];

  assign vld[0] = in_vld_q;
  assign opc[0] = in_op_q;
  assign lr[0]  = in_lr_q;

  for (genvar g = 0; g < R; g++) begin : g_rnd
    des_round u_rnd (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[g]),
      .op_i   (opc[g]),
      .lr_i   (lr[g]),
      .key_i  (opc[g] ? subk_q[R-1-g] : subk_q[g]),
      .vld_o  (vld[g+1]),
      .op_o   (opc[g+1]),
      .lr_o   (lr[g+1])
    );
  end

  // final swap and inverse IP
  logic        out_vld_q;
  logic [63:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld[R];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= des_pkg::fp({lr[R][31:0], lr[R][63:32]});
  end

  assign done_o      = out_vld_q;
  assign block_out_o = out_q;

endmodule

FILE: rtl/des_round.sv
// One Feistel round with its pipeline register.
module des_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  logic                op_i,
  input  logic [63:0]         lr_i,
  input  des_pkg::subkey_t    key_i,
  output logic                vld_o,
  output logic                op_o,
  output logic [63:0]         lr_o
);

  logic [63:0] lr_d, lr_q;
  logic        op_q, vld_q;

  assign lr_d = {lr_i[31:0], lr_i[63:32] ^ des_pkg::feistel(lr_i[31:0], key_i)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lr_q <= lr_d;
    op_q <= op_i;
  end

  assign vld_o = vld_q;
  assign op_o  = op_q;
  assign lr_o  = lr_q;

endmodule

FILE: bench/tb_des_block_cipher.sv
`timescale 1ns / 100ps

module tb_des_block_cipher;

  typedef struct {
    logic        op;
    logic [63:0] block;
  } des_beat_t;

  localparam int unsigned NumRandom = 1650;
  localparam int unsigned Latency   = 18;
  localparam logic        OpEnc     = 1'b0;
  localparam logic        OpDec     = 1'b1;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        op_i;
  logic [63:0] block_in_i;
  logic        key_we_i;
  logic [63:0] cipher_key_i;
  logic        done_o;
  logic [63:0] block_out_o;

  des_beat_t        pending_q[$];
  logic [63:0]      expected_blocks_q[$];
  des_pkg::subkey_t sched[16];
  int unsigned      n_errors;
  int unsigned      n_sent;
  int unsigned      n_checked;
  int unsigned      n_keys;
  int unsigned      gap_left;
  bit               quiet_tail;
  bit               taken;

  des_block_cipher DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .op_i        (op_i),
    .block_in_i  (block_in_i),
    .key_we_i    (key_we_i),
    .cipher_key_i(cipher_key_i),
    .done_o      (done_o),
    .block_out_o (block_out_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] permute64(input logic [63:0] v, input int tbl_sel);
    logic [63:0] r;
    int          src;
    for (int i = 0; i < 64; i++) begin
      src = (tbl_sel == 0) ? int'(des_pkg::TblIp[i]) : int'(des_pkg::TblFp[i]);
      r[63-i] = v[64-src];
    end
    return r;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] x, input int n);
    for (int i = 0; i < n; i++) x = {x[26:0], x[27]};
    return x;
  endfunction

  task automatic load_schedule(input logic [63:0] key);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [55:0] joined;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(des_pkg::TblPc1[i])];
    c = cd[55:28];
    d = cd[27:0];
    for (int r = 0; r < 16; r++) begin
      c = rot28(c, int'(des_pkg::TblShift[r]));
      d = rot28(d, int'(des_pkg::TblShift[r]));
      joined = {c, d};
      for (int i = 0; i < 48; i++) sched[r][47-i] = joined[56-int'(des_pkg::TblPc2[i])];
    end
  endtask

  function automatic logic [31:0] round_fn(input logic [31:0] rh,
                                           input des_pkg::subkey_t k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = rh[32-int'(des_pkg::TblE[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      six = x[(7-i)*6 +: 6];
      s[(7-i)*4 +: 4] = des_pkg::TblS[i][{six[5], six[0], six[4:1]}][3:0];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(des_pkg::TblP[i])];
    return p;
  endfunction

  function automatic logic [63:0] cipher_block(input logic op, input logic [63:0] blk);
    logic [63:0] b;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    b = permute64(blk, 0);
    l = b[63:32];
    r = b[31:0];
    for (int i = 0; i < 16; i++) begin
      t = l ^ round_fn(r, sched[(op == OpDec) ? 15 - i : i]);
      l = r;
      r = t;
    end
    return permute64({r, l}, 1);
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    n_errors++;
    $display("MISMATCH %s at %0t: got %h expected %h", what, $realtime, got, want);
  endtask

  // note each beat at the edge that takes it
  always @(posedge clk_i) begin
    taken = 1'b0;
    if (rst_ni && start_i && !busy_o) begin
      expected_blocks_q.push_back(cipher_block(op_i, block_in_i));
      n_sent++;
      taken = 1'b1;
    end
  end

  // driver: hold start until the beat is taken, idle in random bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start_i || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 8) - 1;
            start_i <= 1'b0;
          end else begin
            start_i    <= 1'b1;
            op_i       <= pending_q[0].op;
            block_in_i <= pending_q[0].block;
            void'(pending_q.pop_front());
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_blocks_q.size() == 0) begin
        report("unexpected result", block_out_o, 64'h0);
      end else begin
        if (block_out_o !== expected_blocks_q[0])
          report("block_out", block_out_o, expected_blocks_q[0]);
        void'(expected_blocks_q.pop_front());
        n_checked++;
      end
    end
  end

  task automatic queue_beat(input logic op, input logic [63:0] blk);
    des_beat_t b;
    b.op = op;
    b.block = blk;
    pending_q.push_back(b);
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !start_i);
    wait (expected_blocks_q.size() == 0);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // key changes only while idle; the block re-derives its schedule behind busy
  task automatic write_key(input logic [63:0] key);
    @(negedge clk_i);
    key_we_i     <= 1'b1;
    cipher_key_i <= key;
    @(negedge clk_i);
    key_we_i <= 1'b0;
    load_schedule(key);
    n_keys++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edgy64();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      3: return ~(64'h1 << $urandom_range(0, 63));
      default: return rand64();
    endcase
  endfunction

  initial begin
    logic [63:0] pt;
    logic [63:0] ct;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    op_i         = OpEnc;
    block_in_i   = '0;
    key_we_i     = 1'b0;
    cipher_key_i = '0;
    n_errors = 0; n_sent = 0; n_checked = 0; n_keys = 0;
    gap_left = 0; quiet_tail = 0; taken = 0;
    load_schedule(64'h0);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset key, extremes of the block
    queue_beat(OpEnc, 64'h0);
    queue_beat(OpEnc, '1);
    queue_beat(OpDec, 64'h0);
    queue_beat(OpDec, '1);
    queue_beat(OpEnc, 64'h8000_0000_0000_0001);
    drain();

    // textbook vector, both directions, then parity bits flipped only, then the all-ones key
    write_key(64'h1334_5779_9BBC_DFF1);
    queue_beat(OpEnc, 64'h0123_4567_89AB_CDEF);
    queue_beat(OpDec, 64'h85E8_1354_0F0A_B405);
    drain();
    write_key(64'h1334_5779_9BBC_DFF1 ^ 64'h0101_0101_0101_0101);
    queue_beat(OpEnc, 64'h0123_4567_89AB_CDEF);
    queue_beat(OpDec, 64'h0123_4567_89AB_CDEF);
    drain();
    write_key('1);
    queue_beat(OpEnc, 64'h0);
    queue_beat(OpDec, '1);
    queue_beat(OpEnc, 64'h5555_5555_AAAA_AAAA);
    drain();

    // random: mostly round trips under fresh keys, some raw decrypts
    for (int phase = 0; phase < 12; phase++) begin
      write_key(phase == 11 ? 64'h0 : edgy64());
      if (phase == 11) quiet_tail = 1;
      for (int i = 0; i < NumRandom / 24; i++) begin
        pt = edgy64();
        ct = cipher_block(OpEnc, pt);
        queue_beat(OpEnc, pt);
        queue_beat(OpDec, $urandom_range(0, 3) == 0 ? pt : ct);
      end
      drain();
    end

    $display("Sent %0d blocks, checked %0d results across %0d key loads.",
             n_sent, n_checked, n_keys);
    if (n_errors == 0 && expected_blocks_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
